/* sv/qrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

  localparam int COEF_W = 16;
  localparam int KIND_W = 3;
  localparam int VAL_W  = 40;
  localparam int DISC_W = 35;  // signed discriminant
  localparam int MAG_W  = 34;  // magnitude of the discriminant
  localparam int DEN_W  = 17;  // magnitude of 2a or of b

  localparam logic [KIND_W-1:0] KIND_REAL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CPLX = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LIN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ALL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd4;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [VAL_W-1:0]  val_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
  } coefs_t;

  typedef struct packed {
    coefs_t coef;
    logic   d_neg;
  } sq_tag_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              neg1;
    logic              neg2;
  } div_tag_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    val_t              first;
    val_t              second;
  } res_t;

endpackage
`default_nettype wire

/* sv/qrs_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface qrs_in_if;
  logic                  valid;
  logic                  ready;
  qrs_pkg::coef_t        coef_a;
  qrs_pkg::coef_t        coef_b;
  qrs_pkg::coef_t        coef_c;
  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if;
  logic                          valid;
  logic                          ready;
  logic [qrs_pkg::KIND_W-1:0]    solution_kind;
  qrs_pkg::val_t                 first_value;
  qrs_pkg::val_t                 second_value;
  modport source (output valid, output solution_kind, output first_value,
                  output second_value, input ready);
  modport sink   (input valid, input solution_kind, input first_value,
                  input second_value, output ready);
endinterface
`default_nettype wire

/* sv/quadratic_root_solver.sv */
`timescale 1ns / 1ps
`default_nettype none
// Quadratic root solver. Each input transaction carries a, b, c of
// a*x^2 + b*x + c = 0 as signed 16-bit integers; each one yields exactly one
// output transaction with solution_kind (two real roots, complex pair, linear
// root, every x, no x) and two signed Q23.16 values (FRAC_BITS fraction bits),
// square root and quotients truncated, values clamped to 40 bits, unused
// values zero. The block takes a new transaction every cycle while its skid
// register is empty. The pipeline runs through the discriminant stages, a square
// root pipeline stage for each root bit, the register that forms numerators, a
// divider pipeline stage for each quotient bit, and the output register. When
// the sink stalls, one extra result is held in a skid register and the whole
// pipeline holds until it drains.
module quadratic_root_solver #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qrs_in_if.sink     in_ch,
  qrs_out_if.source  out_ch
);
  import qrs_pkg::*;

  localparam int ROOT_W = MAG_W / 2 + FRAC_BITS;
  localparam int NUM_W  = COEF_W + 2 + FRAC_BITS;
  localparam int SN_W   = NUM_W + 1;
  localparam int WIDE_W = (SN_W > VAL_W) ? SN_W : VAL_W + 1;

  // pipeline advance: hold everything while the skid register is full
  logic en;
  logic skid_v_r;
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // discriminant
  coefs_t           in_coef;
  logic             dv;
  logic [MAG_W-1:0] dmag;
  sq_tag_t          dtag;

  assign in_coef = '{a: in_ch.coef_a, b: in_ch.coef_b, c: in_ch.coef_c};

  qrs_disc u_disc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_ch.valid),
    .in_coef (in_coef),
    .out_v   (dv),
    .out_mag (dmag),
    .out_tag (dtag)
  );

  // square root of |d| with FRAC_BITS fraction bits
  logic              sv;
  logic [ROOT_W-1:0] sroot;
  sq_tag_t           stag;

  qrs_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (dv),
    .in_mag   (dmag),
    .in_tag   (dtag),
    .out_v    (sv),
    .out_root (sroot),
    .out_tag  (stag)
  );

  // classify and form numerator magnitudes, divisor magnitude and signs
  logic signed [SN_W-1:0]  b_w, c_w, s_w, nb, nc, num1, num2;
  logic signed [DEN_W:0]   den_s;
  logic [DEN_W-1:0]        den_mag, b_mag;
  logic [KIND_W-1:0]       kind;
  div_tag_t                ntag_nxt, ntag_r;
  logic [NUM_W-1:0]        n1_nxt, n2_nxt, n1_r, n2_r;
  logic [DEN_W-1:0]        dv_nxt, dv_r;
  logic                    nv_r;

  assign b_w     = SN_W'(stag.coef.b);
  assign c_w     = SN_W'(stag.coef.c);
  assign s_w     = signed'(SN_W'(sroot));
  assign nb      = -(b_w <<< FRAC_BITS);
  assign nc      = -(c_w <<< FRAC_BITS);
  assign den_s   = (DEN_W + 1)'(stag.coef.a) <<< 1;
  assign den_mag = den_s[DEN_W] ? DEN_W'(-den_s) : DEN_W'(den_s);
  assign b_mag   = stag.coef.b[COEF_W-1] ? DEN_W'(-(DEN_W + 1)'(stag.coef.b))
                                         : DEN_W'(stag.coef.b);

  always_comb begin
    if (stag.coef.a != '0) begin
      kind = stag.d_neg ? KIND_CPLX : KIND_REAL;
    end else if (stag.coef.b != '0) begin
      kind = KIND_LIN;
    end else begin
      kind = (stag.coef.c == '0) ? KIND_ALL : KIND_NONE;
    end
  end

  always_comb begin
    num1     = '0;
    num2     = '0;
    dv_nxt   = den_mag;
    ntag_nxt = '{kind: kind, neg1: 1'b0, neg2: 1'b0};
    case (kind)
      KIND_REAL: begin
        num1          = nb + s_w;
        num2          = nb - s_w;
        ntag_nxt.neg1 = num1[SN_W-1] ^ stag.coef.a[COEF_W-1];
        ntag_nxt.neg2 = num2[SN_W-1] ^ stag.coef.a[COEF_W-1];
      end
      KIND_CPLX: begin
        num1          = nb;
        num2          = s_w;
        ntag_nxt.neg1 = num1[SN_W-1] ^ stag.coef.a[COEF_W-1];
      end
      KIND_LIN: begin
        num1          = nc;
        dv_nxt        = b_mag;
        ntag_nxt.neg1 = num1[SN_W-1] ^ stag.coef.b[COEF_W-1];
      end
      default: begin
        num1 = '0;
      end
    endcase
  end

  assign n1_nxt = num1[SN_W-1] ? NUM_W'(-num1) : NUM_W'(num1);
  assign n2_nxt = num2[SN_W-1] ? NUM_W'(-num2) : NUM_W'(num2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (en) begin
      nv_r <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r   <= n1_nxt;
      n2_r   <= n2_nxt;
      dv_r   <= dv_nxt;
      ntag_r <= ntag_nxt;
    end
  end

  // unsigned division of both lanes by the shared divisor
  logic             qv;
  logic [NUM_W-1:0] q1, q2;
  div_tag_t         qtag;

  qrs_div #(.NUM_W(NUM_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (nv_r),
    .in_n1   (n1_r),
    .in_n2   (n2_r),
    .in_den  (dv_r),
    .in_tag  (ntag_r),
    .out_v   (qv),
    .out_q1  (q1),
    .out_q2  (q2),
    .out_tag (qtag)
  );

  // restore signs, clamp to 40 bits, zero the unused values
  logic signed [WIDE_W-1:0] w1, w2, hi_w, lo_w;
  val_t                     sat1, sat2;
  res_t                     res;

  assign hi_w = signed'({{(WIDE_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}});
  assign lo_w = ~hi_w;
  assign w1   = qtag.neg1 ? -signed'(WIDE_W'(q1)) : signed'(WIDE_W'(q1));
  assign w2   = qtag.neg2 ? -signed'(WIDE_W'(q2)) : signed'(WIDE_W'(q2));
  assign sat1 = (w1 > hi_w) ? VAL_W'(hi_w) : (w1 < lo_w) ? VAL_W'(lo_w) : VAL_W'(w1);
  assign sat2 = (w2 > hi_w) ? VAL_W'(hi_w) : (w2 < lo_w) ? VAL_W'(lo_w) : VAL_W'(w2);

  always_comb begin
    res.kind   = qtag.kind;
    res.first  = '0;
    res.second = '0;
    case (qtag.kind)
      KIND_REAL, KIND_CPLX: begin
        res.first  = sat1;
        res.second = sat2;
      end
      KIND_LIN: begin
        res.first = sat1;
      end
      default: begin
        res.first = '0;
      end
    endcase
  end

  // output register plus skid: take a new result while one still waits
  logic out_v_r;
  res_t out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ch.ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= qv;
    end else if (qv) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ch.ready) begin
        out_r <= skid_r;
      end
    end else if (!out_v_r || out_ch.ready) begin
      out_r <= res;
    end else begin
      skid_r <= res;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.solution_kind = out_r.kind;
  assign out_ch.first_value   = out_r.first;
  assign out_ch.second_value  = out_r.second;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds a result with output empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid filled without an output stall");

  a_trivial_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_r.kind == KIND_ALL || out_r.kind == KIND_NONE))
      |-> (out_r.first == '0 && out_r.second == '0))
    else $error("nonzero value for a degenerate equation");

  a_imag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.kind == KIND_CPLX) |-> !out_r.second[VAL_W-1])
    else $error("negative imaginary magnitude");
`endif

endmodule
`default_nettype wire

/* sv/qrs_disc.sv */
`timescale 1ns / 1ps
`default_nettype none
module qrs_disc (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_v,
  input  wire qrs_pkg::coefs_t         in_coef,
  output logic                         out_v,
  output logic [qrs_pkg::MAG_W-1:0]    out_mag,
  output qrs_pkg::sq_tag_t             out_tag
);
  import qrs_pkg::*;

  logic                v1_r;
  coefs_t              coef1_r;
  logic signed [31:0]  bb_r, bb_nxt;
  logic signed [31:0]  ac_r, ac_nxt;

  logic                v2_r;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  sq_tag_t             tag_r, tag_nxt;
  logic signed [DISC_W-1:0] d_w;

  // stage one: the two products
  assign bb_nxt = 32'(in_coef.b) * 32'(in_coef.b);
  assign ac_nxt = 32'(in_coef.a) * 32'(in_coef.c);

  // stage two: b*b - 4ac and its magnitude
  assign d_w     = DISC_W'(bb_r) - (DISC_W'(ac_r) <<< 2);
  assign mag_nxt = d_w[DISC_W-1] ? MAG_W'(-d_w) : MAG_W'(d_w);
  assign tag_nxt = '{coef: coef1_r, d_neg: d_w[DISC_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef1_r <= in_coef;
      bb_r    <= bb_nxt;
      ac_r    <= ac_nxt;
      mag_r   <= mag_nxt;
      tag_r   <= tag_nxt;
    end
  end

  assign out_v   = v2_r;
  assign out_mag = mag_r;
  assign out_tag = tag_r;

endmodule
`default_nettype wire

/* sv/qrs_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       en,
  input  wire logic                                       in_v,
  input  wire logic [qrs_pkg::MAG_W-1:0]                  in_mag,
  input  wire qrs_pkg::sq_tag_t                           in_tag,
  output logic                                            out_v,
  output logic [qrs_pkg::MAG_W/2+FRAC_BITS-1:0]           out_root,
  output qrs_pkg::sq_tag_t                                out_tag
);
  import qrs_pkg::*;

  localparam int ROOT_W = MAG_W / 2 + FRAC_BITS;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NSTG   = ROOT_W;
  localparam int NPAIR  = MAG_W / 2;

  logic              v_r    [NSTG];
  logic [ROOT_W-1:0] root_r [NSTG];
  logic [REM_W-1:0]  rem_r  [NSTG];
  logic [MAG_W-1:0]  rad_r  [NSTG];
  sq_tag_t           tag_r  [NSTG];

  logic              src_v    [NSTG];
  logic [ROOT_W-1:0] src_root [NSTG];
  logic [REM_W-1:0]  src_rem  [NSTG];
  logic [MAG_W-1:0]  src_rad  [NSTG];
  sq_tag_t           src_tag  [NSTG];

  // one result bit per stage; radicand pairs run out after NPAIR stages
  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic [1:0]        pair;
    logic [REM_W-1:0]  rem_sh, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_v[k]    = in_v;
      assign src_root[k] = '0;
      assign src_rem[k]  = '0;
      assign src_rad[k]  = in_mag;
      assign src_tag[k]  = in_tag;
    end else begin : g_rest
      assign src_v[k]    = v_r[k-1];
      assign src_root[k] = root_r[k-1];
      assign src_rem[k]  = rem_r[k-1];
      assign src_rad[k]  = rad_r[k-1];
      assign src_tag[k]  = tag_r[k-1];
    end

    assign pair   = (k < NPAIR) ? src_rad[k][MAG_W-1 -: 2] : 2'b00;
    assign rem_sh = {src_rem[k][REM_W-3:0], pair};
    assign trial  = {src_root[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {src_root[k][ROOT_W-2:0], ge};
        rad_r[k]  <= src_rad[k] << 2;
        tag_r[k]  <= src_tag[k];
      end
    end
  end

  assign out_v    = v_r[NSTG-1];
  assign out_root = root_r[NSTG-1];
  assign out_tag  = tag_r[NSTG-1];

endmodule
`default_nettype wire

/* sv/qrs_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module qrs_div #(
  parameter int NUM_W = 34
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_v,
  input  wire logic [NUM_W-1:0]           in_n1,
  input  wire logic [NUM_W-1:0]           in_n2,
  input  wire logic [qrs_pkg::DEN_W-1:0]  in_den,
  input  wire qrs_pkg::div_tag_t          in_tag,
  output logic                            out_v,
  output logic [NUM_W-1:0]                out_q1,
  output logic [NUM_W-1:0]                out_q2,
  output qrs_pkg::div_tag_t               out_tag
);
  import qrs_pkg::*;

  localparam int NSTG = NUM_W;

  // two lanes share the divisor; numerator bits shift out, quotient bits in
  logic              v_r   [NSTG];
  logic [NUM_W-1:0]  n_r   [2][NSTG];
  logic [DEN_W-1:0]  r_r   [2][NSTG];
  logic [DEN_W-1:0]  den_r [NSTG];
  div_tag_t          tag_r [NSTG];

  logic              src_v   [NSTG];
  logic [NUM_W-1:0]  src_n   [2][NSTG];
  logic [DEN_W-1:0]  src_r   [2][NSTG];
  logic [DEN_W-1:0]  src_den [NSTG];
  div_tag_t          src_tag [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    if (k == 0) begin : g_first
      assign src_v[k]    = in_v;
      assign src_n[0][k] = in_n1;
      assign src_n[1][k] = in_n2;
      assign src_r[0][k] = '0;
      assign src_r[1][k] = '0;
      assign src_den[k]  = in_den;
      assign src_tag[k]  = in_tag;
    end else begin : g_rest
      assign src_v[k]    = v_r[k-1];
      assign src_n[0][k] = n_r[0][k-1];
      assign src_n[1][k] = n_r[1][k-1];
      assign src_r[0][k] = r_r[0][k-1];
      assign src_r[1][k] = r_r[1][k-1];
      assign src_den[k]  = den_r[k-1];
      assign src_tag[k]  = tag_r[k-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DEN_W:0] pr, diff;
      logic           ge;
      assign pr   = {src_r[l][k], src_n[l][k][NUM_W-1]};
      assign diff = pr - {1'b0, src_den[k]};
      assign ge   = (pr >= {1'b0, src_den[k]});
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[l][k] <= ge ? diff[DEN_W-1:0] : pr[DEN_W-1:0];
          n_r[l][k] <= {src_n[l][k][NUM_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= src_den[k];
        tag_r[k] <= src_tag[k];
      end
    end
  end

  assign out_v   = v_r[NSTG-1];
  assign out_q1  = n_r[0][NSTG-1];
  assign out_q2  = n_r[1][NSTG-1];
  assign out_tag = tag_r[NSTG-1];

endmodule
`default_nettype wire

/* verif/qrs_tb_if.sv */
`timescale 1ns / 1ps
// The channel interfaces live with the RTL; this file is kept for the
// testbench-side build order and declares nothing the RTL already has.
package qrs_tb_types;
  typedef struct {
    logic [2:0]        kind;
    logic signed [39:0] first;
    logic signed [39:0] second;
  } root_exp_t;
endpackage

/* verif/quadratic_root_solver_tb.sv */
`timescale 1ns / 1ps
module quadratic_root_solver_tb;
  import qrs_pkg::*;
  import qrs_tb_types::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 2 + (17 + FRAC) + 1 + (18 + FRAC) + 1;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  qrs_in_if  in_ch();
  qrs_out_if out_ch();

  quadratic_root_solver #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  int mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  // Predict roots from one coefficient triple, keep expected results in order.
  class root_scoreboard;
    root_exp_t pending_roots[$];

    function automatic longint isqrt_scaled(longint unsigned m);
      longint unsigned root, rem, pair, trial;
      root = 0;
      rem = 0;
      for (int i = 16 + FRAC; i >= 0; i--) begin
        pair = (i >= FRAC) ? ((m >> (2 * (i - FRAC))) & 3) : 0;
        rem = (rem << 2) | pair;
        trial = (root << 2) | 1;
        if (rem >= trial) begin
          rem -= trial;
          root = (root << 1) | 1;
        end else begin
          root = root << 1;
        end
      end
      return longint'(root);
    endfunction

    function automatic logic signed [39:0] clamp40(longint v);
      if (v > 64'sd549755813887) return 40'sh7F_FFFF_FFFF;
      if (v < -64'sd549755813888) return 40'sh80_0000_0000;
      return v[39:0];
    endfunction

    // Note an accepted input transaction.
    function automatic void note_coefs(coef_t ca, coef_t cb, coef_t cc);
      longint a, b, c, one, den, disc, s, v1, v2;
      root_exp_t e;
      a = ca;
      b = cb;
      c = cc;
      one = 64'sd1 << FRAC;
      v1 = 0;
      v2 = 0;
      if (a != 0) begin
        den = 2 * a;
        disc = b * b - 4 * a * c;
        if (disc >= 0) begin
          s = isqrt_scaled(disc);
          v1 = (-b * one + s) / den;
          v2 = (-b * one - s) / den;
          e.kind = KIND_REAL;
        end else begin
          s = isqrt_scaled(-disc);
          v1 = (-b * one) / den;
          v2 = s / (den < 0 ? -den : den);
          e.kind = KIND_CPLX;
        end
      end else if (b != 0) begin
        v1 = (-c * one) / b;
        e.kind = KIND_LIN;
      end else begin
        e.kind = (c == 0) ? KIND_ALL : KIND_NONE;
      end
      e.first = clamp40(v1);
      e.second = clamp40(v2);
      pending_roots.push_back(e);
    endfunction

    // Check one output transaction against the oldest prediction.
    task automatic check_roots(logic [2:0] k, val_t f, val_t s);
      root_exp_t e;
      if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d", k));
        return;
      end
      e = pending_roots.pop_front();
      if (k !== e.kind)
        report_mismatch($sformatf("kind got %0d want %0d", k, e.kind));
      if (f !== e.first)
        report_mismatch($sformatf("first got %0d want %0d", f, e.first));
      if (s !== e.second)
        report_mismatch($sformatf("second got %0d want %0d", s, e.second));
    endtask
  endclass

  root_scoreboard sb = new();

  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  sink_stall_on = 1'b1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;
    out_ch.ready = 1'b0;
  end

  // Sample both channels at the rising edge; predict and check there.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_coefs(in_ch.coef_a, in_ch.coef_b, in_ch.coef_c);
      if (out_ch.valid && out_ch.ready)
        sb.check_roots(out_ch.solution_kind, out_ch.first_value, out_ch.second_value);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: stall on its own pattern; hold off entirely when asked.
  always @(negedge clk) begin
    if (!rst_n || hold_off)
      out_ch.ready <= 1'b0;
    else if (sink_stall_on)
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    else
      out_ch.ready <= 1'b1;
  end

  // Offer one transaction; hold it until accepted.
  task automatic send_coefs(coef_t a, coef_t b, coef_t c);
    in_ch.valid <= 1'b1;
    in_ch.coef_a <= a;
    in_ch.coef_b <= b;
    in_ch.coef_c <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  function automatic coef_t pick_coef();
    case ($urandom_range(0, 5))
      0: return coef_t'(0);
      1: return coef_t'(16'sh7FFF);
      2: return coef_t'(16'sh8000);
      3: return coef_t'($urandom_range(0, 8) - 4);
      default: return coef_t'($urandom);
    endcase
  endfunction

  // Send count random coefficient triples in bursts, with random gaps between.
  // Drop valid only where a gap follows; a gap always follows the last burst.
  task automatic send_random(int count);
    int burst;
    int gap;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        send_coefs(pick_coef(), pick_coef(), pick_coef());
        burst--;
        count--;
      end
      gap = $urandom_range(0, 4);
      if (count == 0 && gap == 0)
        gap = 1;
      if (gap > 0) begin
        drop_valid();
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_roots.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: each solution kind, coefficient extremes, perfect squares.
    send_coefs(1, -3, 2);
    send_coefs(1, 2, 1);
    send_coefs(1, 0, 1);
    send_coefs(-1, 0, 1);
    send_coefs(-3, 2, 5);
    send_coefs(0, 3, 7);
    send_coefs(0, -1, -32768);
    send_coefs(0, 0, 0);
    send_coefs(0, 0, 5);
    send_coefs(1, -32768, -32768);
    send_coefs(1, 32767, 32767);
    send_coefs(-32768, -32768, 32767);
    send_coefs(32767, 32767, 32767);
    send_coefs(-32768, 0, -32768);
    send_coefs(1, -32768, 0);
    send_coefs(0, 1, -32768);
    send_coefs(-1, -1, -1);
    send_coefs(2, 0, -2);
    drop_valid();

    // Pause until every expected result has come.
    wait_drained();

    // Receiver holds off for a long stretch while input keeps coming.
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      send_random(150);
    join

    sink_stall_on = 1'b0;
    send_random(150);
    sink_stall_on = 1'b1;
    send_random(200);

    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0 && sb.pending_roots.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

/* filelist.f */
sv/qrs_pkg.sv
sv/qrs_if.sv
sv/qrs_disc.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver.sv
verif/qrs_tb_if.sv
verif/quadratic_root_solver_tb.sv
